// ----- hw/rtl/rrt_pkg.sv -----
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and codes of the received range tracker.
// ----------------------------------------------------------------------------
package rrt_pkg;

   localparam int FIELD_BITS    = 48;
   localparam int COUNT_BITS    = 5;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = 96;
   localparam int RSP_DATA_BITS = 56;

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_MERGED   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_QUERY    = 2'd3;

   typedef struct packed {
      logic overlap;
      logic ahead;
      logic stop;
      logic grow;
   } walk_flags_type;

endpackage

// ----- hw/rtl/rrt_table.sv -----
// ----------------------------------------------------------------------------
// rrt_table
// Range table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrt_table #(
   parameter int ENTRIES     = 16,
   parameter int OFFSET_BITS = 48
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [OFFSET_BITS-1:0]     wr_start,
   input  logic [OFFSET_BITS-1:0]     wr_end,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [OFFSET_BITS-1:0]     rd_start,
   output logic [OFFSET_BITS-1:0]     rd_end
);

   logic [2*OFFSET_BITS-1:0] mem [ENTRIES];
   logic [2*OFFSET_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_end, wr_start};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_start = rd_data_ff[OFFSET_BITS-1:0];
   assign rd_end   = rd_data_ff[2*OFFSET_BITS-1:OFFSET_BITS];

endmodule

// ----- hw/rtl/rrt_walk_unit.sv -----
// ----------------------------------------------------------------------------
// rrt_walk_unit
// Shared compare unit: tests one stored range against the candidate range
// or the running query end, and forms the union.
// ----------------------------------------------------------------------------
module rrt_walk_unit #(
   parameter int OFFSET_BITS = 48
) (
   input  logic [OFFSET_BITS-1:0] cand_start,
   input  logic [OFFSET_BITS-1:0] cand_end,
   input  logic [OFFSET_BITS-1:0] reach,
   input  logic [OFFSET_BITS-1:0] ent_start,
   input  logic [OFFSET_BITS-1:0] ent_end,
   output rrt_pkg::walk_flags_type flags,
   output logic [OFFSET_BITS-1:0] union_start,
   output logic [OFFSET_BITS-1:0] union_end
);

   always_comb begin
      flags.overlap = (cand_start <= ent_end) && (cand_end >= ent_start);
      flags.ahead   = cand_end < ent_start;
      flags.stop    = (ent_start > reach) && (ent_start > cand_start);
      flags.grow    = ent_end > reach;
      union_start   = (cand_start < ent_start) ? cand_start : ent_start;
      union_end     = (cand_end > ent_end) ? cand_end : ent_end;
   end

endmodule

// ----- hw/rtl/received_range_tracker.sv -----
// ----------------------------------------------------------------------------
// received_range_tracker
// Scoreboard of received byte ranges with merge, insert and completion query.
// ----------------------------------------------------------------------------
// One word is worked on at a time and req_tready is high only while the block
// is idle; a finished result waits in the output register so the next word
// can be taken meanwhile. The stored ranges sit in a single-port-read memory
// that is walked one entry per cycle; an inserting record then moves the
// entries at and above its slot up one slot at a time through the same read
// port. No clearing pass is needed after reset: only entries below the fill
// count are ever read.
// ----------------------------------------------------------------------------
module received_range_tracker #(
   parameter int ENTRIES     = 16,
   parameter int OFFSET_BITS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rrt_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // position, length
   input  logic                                req_tuser,  // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rrt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // covered_end, entry_count
   output logic [rrt_pkg::STATUS_BITS-1:0]     rsp_tuser   // status
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int OW = OFFSET_BITS;
   localparam int FB = rrt_pkg::FIELD_BITS;
   localparam int NB = rrt_pkg::COUNT_BITS;
   localparam int SB = rrt_pkg::STATUS_BITS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   localparam logic [CW-1:0] ENTRIES_CNT = CW'(ENTRIES);

   logic [1:0]    state_ff, state_in;
   logic          mode_ff, mode_in;
   logic [OW-1:0] b0_ff, b0_in;
   logic [OW-1:0] e0_ff, e0_in;
   logic [OW-1:0] reach_ff, reach_in;
   logic          first_ff, first_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          dv_ff, dv_in;
   logic [AW-1:0] didx_ff, didx_in;
   logic          ins_found_ff, ins_found_in;
   logic [CW-1:0] ins_ff, ins_in;
   logic [CW-1:0] k_ff, k_in;
   logic          sv_ff, sv_in;
   logic [AW-1:0] wk_ff, wk_in;
   logic [SB-1:0] status_ff, status_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [FB-1:0] rsp_covered_ff, rsp_covered_in;
   logic [SB-1:0] rsp_status_ff, rsp_status_in;
   logic [NB-1:0] rsp_count_ff, rsp_count_in;

   logic [OW+FB-1:0] pos_ext, len_ext;
   logic [OW-1:0]    pos_w, len_w;
   logic [OW:0]      end_sum;
   logic [OW-1:0]    end_sat;
   logic [CW-1:0]    km1;
   logic [OW+FB-1:0] reach_ext;
   logic [CW+NB-1:0] count_ext;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [OW-1:0] wr_start, wr_end, rd_start, rd_end;
   logic [OW-1:0] union_start, union_end;
   rrt_pkg::walk_flags_type flags;

   rrt_table #(
      .ENTRIES     (ENTRIES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_start (wr_start),
      .wr_end   (wr_end),
      .rd_addr  (rd_addr),
      .rd_start (rd_start),
      .rd_end   (rd_end)
   );

   rrt_walk_unit #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_walk (
      .cand_start  (b0_ff),
      .cand_end    (e0_ff),
      .reach       (reach_ff),
      .ent_start   (rd_start),
      .ent_end     (rd_end),
      .flags       (flags),
      .union_start (union_start),
      .union_end   (union_end)
   );

   // input offsets reduced to the offset width, end saturated
   assign pos_ext   = {{OW{1'b0}}, req_tdata[FB-1:0]};
   assign len_ext   = {{OW{1'b0}}, req_tdata[2*FB-1:FB]};
   assign pos_w     = pos_ext[OW-1:0];
   assign len_w     = len_ext[OW-1:0];
   assign end_sum   = {1'b0, pos_w} + {1'b0, len_w};
   assign end_sat   = end_sum[OW] ? {OW{1'b1}} : end_sum[OW-1:0];
   assign km1       = k_ff - CW'(1);
   assign reach_ext = {{FB{1'b0}}, reach_ff};
   assign count_ext = {{NB{1'b0}}, count_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(rrt_pkg::RSP_DATA_BITS - FB - NB){1'b0}}, rsp_count_ff,
                        rsp_covered_ff};
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      b0_in          = b0_ff;
      e0_in          = e0_ff;
      reach_in       = reach_ff;
      first_in       = first_ff;
      idx_in         = idx_ff;
      dv_in          = dv_ff;
      didx_in        = didx_ff;
      ins_found_in   = ins_found_ff;
      ins_in         = ins_ff;
      k_in           = k_ff;
      sv_in          = sv_ff;
      wk_in          = wk_ff;
      status_in      = status_ff;
      count_in       = count_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_covered_in = rsp_covered_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = didx_ff;
      wr_start       = b0_ff;
      wr_end         = e0_ff;
      rd_addr        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in      = req_tuser;
               b0_in        = pos_w;
               e0_in        = end_sat;
               reach_in     = pos_w;
               first_in     = 1'b1;
               idx_in       = '0;
               dv_in        = 1'b0;
               ins_found_in = 1'b0;
               ins_in       = count_ff;
               state_in     = S_WALK;
            end
         end
         S_WALK: begin
            // issue the next entry read
            if (idx_ff < count_ff) begin
               rd_addr = idx_ff[AW-1:0];
               dv_in   = 1'b1;
               didx_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else begin
               dv_in = 1'b0;
            end
            // evaluate the entry read last cycle
            if (dv_ff) begin
               if (mode_ff == rrt_pkg::MODE_RECORD) begin
                  if (flags.overlap) begin
                     wr_en     = 1'b1;
                     wr_addr   = didx_ff;
                     wr_start  = union_start;
                     wr_end    = union_end;
                     status_in = rrt_pkg::ST_MERGED;
                     state_in  = S_OUT;
                  end else if (flags.ahead && !ins_found_ff) begin
                     ins_found_in = 1'b1;
                     ins_in       = CW'(didx_ff);
                  end
               end else begin
                  if (flags.stop) begin
                     status_in = rrt_pkg::ST_QUERY;
                     state_in  = S_OUT;
                  end else begin
                     reach_in = (first_ff || flags.grow) ? rd_end : reach_ff;
                     first_in = 1'b0;
                  end
               end
            end else if (idx_ff >= count_ff) begin
               if (mode_ff == rrt_pkg::MODE_QUERY) begin
                  status_in = rrt_pkg::ST_QUERY;
                  state_in  = S_OUT;
               end else if (count_ff == ENTRIES_CNT) begin
                  status_in = rrt_pkg::ST_FULL;
                  state_in  = S_OUT;
               end else begin
                  k_in     = count_ff;
                  sv_in    = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // move entries up one slot, read and write overlapped
            if (sv_ff) begin
               wr_en    = 1'b1;
               wr_addr  = wk_ff;
               wr_start = rd_start;
               wr_end   = rd_end;
            end
            if (k_ff > ins_ff) begin
               rd_addr = km1[AW-1:0];
               sv_in   = 1'b1;
               wk_in   = k_ff[AW-1:0];
               k_in    = km1;
            end else begin
               sv_in = 1'b0;
               if (!sv_ff) begin
                  wr_en     = 1'b1;
                  wr_addr   = ins_ff[AW-1:0];
                  wr_start  = b0_ff;
                  wr_end    = e0_ff;
                  count_in  = count_ff + CW'(1);
                  status_in = rrt_pkg::ST_INSERTED;
                  state_in  = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in  = 1'b1;
               rsp_covered_in = (mode_ff == rrt_pkg::MODE_QUERY) ? reach_ext[FB-1:0] : '0;
               rsp_status_in  = status_ff;
               rsp_count_in   = count_ext[NB-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         dv_ff         <= 1'b0;
         sv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         dv_ff         <= dv_in;
         sv_ff         <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      b0_ff          <= b0_in;
      e0_ff          <= e0_in;
      reach_ff       <= reach_in;
      first_ff       <= first_in;
      idx_ff         <= idx_in;
      didx_ff        <= didx_in;
      ins_found_ff   <= ins_found_in;
      ins_ff         <= ins_in;
      k_ff           <= k_in;
      wk_ff          <= wk_in;
      status_ff      <= status_in;
      rsp_covered_ff <= rsp_covered_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES_CNT)
      else $error("range count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("range count changed by other than one insert");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_WALK) || (state_ff == S_SHIFT)))
      else $error("table written outside walk or shift");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && (status_ff == rrt_pkg::ST_FULL))
         |-> (count_ff == ENTRIES_CNT))
      else $error("drop reported with free table entries");

endmodule

// ----- bench/received_range_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// received_range_tracker_tb
// Self-checking bench for the received range tracker. A short scripted
// sequence builds a table of ranges through merges, front, middle and end
// inserts, a saturated end and a dropped range on a full table, with queries
// on an empty table, inside gaps and near the top of the offset space. Random
// records and queries follow, aimed mostly at the edges of stored ranges.
// Each word updates a local copy of the range table, which predicts the reply
// unless the script fixes it, and responses are compared in order. Both sides
// idle at random, and the receiver holds off once for a long stretch so that
// the block backs up.
module received_range_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ENTRIES     = 16;
   localparam int          RANDOM_WORDS = 1250;
   localparam logic [47:0] OFF_MAX     = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [47:0] covered_end;
      logic [1:0]  status;
      logic [4:0]  entry_count;
   } reply_type;

   typedef struct {
      logic        mode;
      logic [47:0] position;
      logic [47:0] length;
      bit          typed;
      reply_type   want;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [rrt_pkg::REQ_DATA_BITS-1:0] req_tdata;   // position, length
   logic                              req_tuser;   // mode
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [rrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;   // covered_end, entry_count
   logic [rrt_pkg::STATUS_BITS-1:0]   rsp_tuser;   // status

   // local copy of the range table
   logic [47:0] span_start [ENTRIES];
   logic [47:0] span_len   [ENTRIES];
   int          held;

   reply_type    pending_replies [$];
   stim_row_type script [$];
   int           errors;
   int           replies_seen;

   received_range_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [47:0] span_end(input int i);
      return span_start[i] + span_len[i];
   endfunction

   function automatic reply_type track_word(input logic mode, input logic [47:0] pos,
                                            input logic [47:0] len);
      reply_type   r;
      logic [48:0] sum;
      logic [47:0] e0, b1, e1, nb, ne, reach;
      int          idx;
      bit          done;
      r = '0;
      if (mode == rrt_pkg::MODE_RECORD) begin
         sum  = {1'b0, pos} + {1'b0, len};
         e0   = (sum > {1'b0, OFF_MAX}) ? OFF_MAX : sum[47:0];
         done = 1'b0;
         for (int i = 0; i < held; i++) begin
            if (!done) begin
               b1 = span_start[i];
               e1 = span_end(i);
               if (pos <= e1 && e0 >= b1) begin
                  nb = (pos < b1) ? pos : b1;
                  ne = (e0 > e1) ? e0 : e1;
                  span_start[i] = nb;
                  span_len[i]   = ne - nb;
                  r.status      = rrt_pkg::ST_MERGED;
                  done          = 1'b1;
               end
            end
         end
         if (!done) begin
            if (held >= ENTRIES) begin
               r.status = rrt_pkg::ST_FULL;
            end else begin
               idx = held;
               for (int i = 0; i < held; i++) begin
                  if (idx == held && e0 < span_start[i]) idx = i;
               end
               for (int k = held; k > idx; k--) begin
                  span_start[k] = span_start[k-1];
                  span_len[k]   = span_len[k-1];
               end
               span_start[idx] = pos;
               span_len[idx]   = e0 - pos;
               held++;
               r.status = rrt_pkg::ST_INSERTED;
            end
         end
      end else begin
         r.status = rrt_pkg::ST_QUERY;
         if (held == 0 || span_start[0] > pos) begin
            r.covered_end = pos;
         end else begin
            reach = span_end(0);
            done  = 1'b0;
            for (int i = 0; i < held; i++) begin
               if (!done) begin
                  if (span_start[i] > reach && span_start[i] > pos) begin
                     done = 1'b1;
                  end else begin
                     e1 = span_end(i);
                     if (e1 > reach) reach = e1;
                  end
               end
            end
            r.covered_end = reach;
         end
      end
      r.entry_count = 5'(held);
      return r;
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic add_row(input logic mode, input logic [47:0] pos, input logic [47:0] len,
                          input bit typed, input logic [47:0] cov,
                          input logic [1:0] st, input logic [4:0] cnt);
      stim_row_type row;
      row.mode     = mode;
      row.position = pos;
      row.length   = len;
      row.typed    = typed;
      row.want     = '{covered_end: cov, status: st, entry_count: cnt};
      script.insert(script.size(), row);
   endtask

   // sender side: one word per call, held until the block takes it
   task automatic send_word(input logic mode, input logic [47:0] pos, input logic [47:0] len,
                            input bit typed, input reply_type want);
      reply_type guess;
      req_tvalid <= 1'b1;
      req_tdata  <= {len, pos};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      guess = track_word(mode, pos, len);
      pending_replies.insert(pending_replies.size(), typed ? want : guess);
   endtask

   function automatic int pick_gap(input bit busy);
      int r;
      if (busy) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int          gap;
      int          r, i;
      logic        mode;
      logic [47:0] pos, len, base;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= rrt_pkg::MODE_RECORD;
      errors      = 0;
      held        = 0;

      add_row(rrt_pkg::MODE_QUERY,  48'd0,           48'd0,    1, 48'd0,
              rrt_pkg::ST_QUERY,    5'd0);
      add_row(rrt_pkg::MODE_QUERY,  OFF_MAX,         OFF_MAX,  1, OFF_MAX,
              rrt_pkg::ST_QUERY,    5'd0);
      add_row(rrt_pkg::MODE_RECORD, 48'd1000,        48'd0,    1, 48'd0,
              rrt_pkg::ST_INSERTED, 5'd1);
      add_row(rrt_pkg::MODE_RECORD, 48'd1000,        48'd500,  1, 48'd0,
              rrt_pkg::ST_MERGED,   5'd1);
      add_row(rrt_pkg::MODE_RECORD, 48'd1500,        48'd0,    1, 48'd0,
              rrt_pkg::ST_MERGED,   5'd1);
      add_row(rrt_pkg::MODE_RECORD, 48'd3000,        48'd100,  1, 48'd0,
              rrt_pkg::ST_INSERTED, 5'd2);
      add_row(rrt_pkg::MODE_RECORD, 48'd1600,        48'd100,  1, 48'd0,
              rrt_pkg::ST_INSERTED, 5'd3);
      add_row(rrt_pkg::MODE_RECORD, OFF_MAX - 48'd9, OFF_MAX,  1, 48'd0,
              rrt_pkg::ST_INSERTED, 5'd4);
      add_row(rrt_pkg::MODE_RECORD, 48'd0,           48'd10,   1, 48'd0,
              rrt_pkg::ST_INSERTED, 5'd5);
      add_row(rrt_pkg::MODE_QUERY,  48'd1200,        48'd7,    0, 48'd0,
              rrt_pkg::ST_QUERY,    5'd0);
      add_row(rrt_pkg::MODE_QUERY,  48'd500,         48'd0,    0, 48'd0,
              rrt_pkg::ST_QUERY,    5'd0);
      add_row(rrt_pkg::MODE_QUERY,  OFF_MAX - 48'd5, 48'd0,    0, 48'd0,
              rrt_pkg::ST_QUERY,    5'd0);
      for (int k = 10; k >= 0; k--) begin
         add_row(rrt_pkg::MODE_RECORD, 48'd4000 + 48'(2000 * k), 48'd1, 1, 48'd0,
                 rrt_pkg::ST_INSERTED, 5'(16 - k));
      end
      add_row(rrt_pkg::MODE_RECORD, 48'd50000,       48'd1,    1, 48'd0,
              rrt_pkg::ST_FULL,     5'd16);
      add_row(rrt_pkg::MODE_QUERY,  48'd0,           48'd0,    0, 48'd0,
              rrt_pkg::ST_QUERY,    5'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[n]) begin
         send_word(script[n].mode, script[n].position, script[n].length,
                   script[n].typed, script[n].want);
         gap = pick_gap(1'b0);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         mode = ($urandom_range(0, 99) < 35) ? rrt_pkg::MODE_QUERY : rrt_pkg::MODE_RECORD;
         r    = $urandom_range(0, 99);
         i    = $urandom_range(0, held - 1);
         base = $urandom_range(0, 1) ? span_start[i] : span_end(i);
         if (mode == rrt_pkg::MODE_RECORD) begin
            if (r < 65) begin
               pos = base + 48'($urandom_range(0, 128)) - 48'd64;
               len = 48'($urandom_range(0, 128));
            end else if (r < 93) begin
               pos = rand48();
               len = 48'($urandom_range(0, 4096));
            end else if (r < 97) begin
               pos = OFF_MAX - 48'($urandom_range(0, 300));
               len = rand48();
            end else begin
               pos = rand48();
               len = rand48() >> $urandom_range(0, 47);
            end
         end else begin
            len = rand48();
            if (r < 60)      pos = base + 48'($urandom_range(0, 16)) - 48'd8;
            else if (r < 85) pos = rand48();
            else             pos = $urandom_range(0, 1) ? OFF_MAX : 48'd0;
         end
         send_word(mode, pos, len, 1'b0, '0);
         // stretches of back-to-back words
         gap = pick_gap((n % 200) >= 140);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $display("%0t pending responses: expected 0, actual %0d", $time,
                  pending_replies.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   task automatic check_reply();
      reply_type want;
      if (pending_replies.size() == 0) begin
         $display("%0t unexpected word: expected none, actual %h/%0d", $time,
                  rsp_tdata, rsp_tuser);
         errors++;
         return;
      end
      want = pending_replies.pop_front();
      if (rsp_tdata[47:0] !== want.covered_end) begin
         $display("%0t covered_end: expected %h, actual %h", $time,
                  want.covered_end, rsp_tdata[47:0]);
         errors++;
      end
      if (rsp_tuser !== want.status) begin
         $display("%0t status: expected %0d, actual %0d", $time, want.status, rsp_tuser);
         errors++;
      end
      if (rsp_tdata[52:48] !== want.entry_count) begin
         $display("%0t entry_count: expected %0d, actual %0d", $time,
                  want.entry_count, rsp_tdata[52:48]);
         errors++;
      end
   endtask

   // receiver side with random stalls and one long hold-off
   initial begin
      int  stall_left;
      int  cycle;
      bit  held_off;
      bit  ready;
      rsp_tready <= 1'b0;
      replies_seen = 0;
      stall_left   = 0;
      cycle        = 0;
      held_off     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            check_reply();
            replies_seen++;
         end
         if (!held_off && replies_seen == 300) begin
            held_off   = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else begin
            ready = 1'b1;
            if ((cycle % 3000) < 2000 && $urandom_range(0, 99) < 25) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(1, 3);
               ready      = 1'b0;
            end
         end
         rsp_tready <= ready;
         cycle++;
         @(posedge clock);
      end
   end

endmodule
